// File: hdl/fifo_with_expiry_and_keyed_remove_unit_defines.svh
// Assertion macros used by the RTL of the queue block.
`ifndef FIFO_WITH_EXPIRY_AND_KEYED_REMOVE_UNIT_DEFINES_SVH
`define FIFO_WITH_EXPIRY_AND_KEYED_REMOVE_UNIT_DEFINES_SVH

`ifndef SYNTH

`define FWEKR_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("fwekr assertion failed");

`define FWEKR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fwekr assertion failed");

`else

`define FWEKR_ASSERT(label, clk, rst, prop)

`define FWEKR_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// File: hdl/fwekr_pkg.sv
`default_nettype none

package fwekr_pkg;

   localparam int DEPTH_DEFAULT = 16;

   localparam int KeyW   = 31;
   localparam int DayW   = 9;
   localparam int CountW = 5;

   localparam logic [1:0] OP_PUSH   = 2'd0;
   localparam logic [1:0] OP_EXPIRE = 2'd1;
   localparam logic [1:0] OP_REMOVE = 2'd2;
   localparam logic [1:0] OP_NONE   = 2'd3;

   localparam logic [1:0] ST_DONE        = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND   = 2'd1;
   localparam logic [1:0] ST_FULL        = 2'd2;
   localparam logic [1:0] ST_NOT_EXPIRED = 2'd3;

   typedef struct packed {
      logic [1:0]      operation;
      logic [KeyW-1:0] key;
      logic [DayW-1:0] due_day;
      logic [DayW-1:0] current_day;
   } req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [KeyW-1:0]   removed_key;
      logic [CountW-1:0] entry_count;
   } rsp_type;

   typedef struct packed {
      logic [KeyW-1:0] key;
      logic [DayW-1:0] due;
   } entry_type;

endpackage

`default_nettype wire

// File: hdl/fifo_with_expiry_and_keyed_remove_unit.sv
// Ordered queue of up to DEPTH entries, each a key with a due day.
// Requests arrive on req_valid/req_ready with req_data; each transaction
// carries an operation: push at the tail, expire the head if its due day is
// before current_day, or remove the first entry whose key matches.
// Every request yields exactly one response transaction on
// rsp_valid/rsp_ready with rsp_data: status, removed key and entry count.
// Entries live in one memory with a registered read port, addressed as a
// ring from a head pointer. A push, the unused operation code, or an expire
// or remove on an empty queue finishes on acceptance; any other expire first
// reads the head entry, and a remove reads all N entries in order, where N
// is the number of entries held: the search and the compaction behind a
// match stream through the memory at one read and one write per cycle.
// One request is in flight at a time; the next request is accepted in the
// cycle after the response is loaded, even while that response still waits.
// When the receiver stalls, the finished result holds in a staging register
// and the block accepts nothing new until the response register frees up.
// Reset empties the queue and drops any pending response; memory contents
// are left as they are.
`default_nettype none

`include "fifo_with_expiry_and_keyed_remove_unit_defines.svh"

module fifo_with_expiry_and_keyed_remove_unit
   import fwekr_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXP  = 2'd1;
   localparam logic [1:0] S_SCAN = 2'd2;
   localparam logic [1:0] S_DONE = 2'd3;

   logic [1:0]      state_ff, state_in;
   logic [AW-1:0]   head_ff, head_in;
   logic [CW-1:0]   count_ff, count_in;
   logic [KeyW-1:0] key_ff, key_in;
   logic [DayW-1:0] day_ff, day_in;
   logic [CW-1:0]   rd_idx_ff, rd_idx_in;
   logic [AW-1:0]   cmp_idx_ff, cmp_idx_in;
   logic            found_ff, found_in;
   rsp_type         res_ff, res_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_type         rsp_data_ff, rsp_data_in;

   entry_type       mem [DEPTH];
   entry_type       mem_rd_ff;
   logic            mem_we;
   logic [AW-1:0]   mem_wa;
   entry_type       mem_wd;
   logic            mem_re;
   logic [AW-1:0]   mem_ra;

   logic            hit;
   logic            rsp_load;

   function automatic logic [AW-1:0] ring_addr(input logic [AW-1:0] head,
                                               input logic [AW-1:0] idx);
      logic [AW:0] sum;
      sum = {1'b0, head} + {1'b0, idx};
      if (sum >= (AW+1)'(DEPTH)) begin
         sum = sum - (AW+1)'(DEPTH);
      end
      return sum[AW-1:0];
   endfunction

   function automatic rsp_type make_rsp(input logic [1:0]      status,
                                        input logic [KeyW-1:0] removed,
                                        input logic [CW-1:0]   count);
      rsp_type r;
      r.status      = status;
      r.removed_key = removed;
      r.entry_count = CountW'(count);
      return r;
   endfunction

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         mem_rd_ff <= mem[mem_ra];
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign rsp_load  = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ready);
   assign hit       = found_ff || (mem_rd_ff.key == key_ff);

   always_comb begin
      state_in   = state_ff;
      head_in    = head_ff;
      count_in   = count_ff;
      key_in     = key_ff;
      day_in     = day_ff;
      rd_idx_in  = rd_idx_ff;
      cmp_idx_in = cmp_idx_ff;
      found_in   = found_ff;
      res_in     = res_ff;
      mem_we     = 1'b0;
      mem_wa     = '0;
      mem_wd     = '0;
      mem_re     = 1'b0;
      mem_ra     = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               key_in   = req_data.key;
               day_in   = req_data.current_day;
               found_in = 1'b0;
               unique case (req_data.operation)
                  OP_PUSH: begin
                     state_in = S_DONE;
                     if (count_ff == CW'(DEPTH)) begin
                        res_in = make_rsp(ST_FULL, '0, count_ff);
                     end else begin
                        mem_we     = 1'b1;
                        mem_wa     = ring_addr(head_ff, count_ff[AW-1:0]);
                        mem_wd.key = req_data.key;
                        mem_wd.due = req_data.due_day;
                        count_in   = count_ff + 1'b1;
                        res_in     = make_rsp(ST_DONE, '0, count_ff + 1'b1);
                     end
                  end
                  OP_EXPIRE: begin
                     if (count_ff == '0) begin
                        state_in = S_DONE;
                        res_in   = make_rsp(ST_NOT_EXPIRED, '0, count_ff);
                     end else begin
                        state_in = S_EXP;
                        mem_re   = 1'b1;
                        mem_ra   = head_ff;
                     end
                  end
                  OP_REMOVE: begin
                     if (count_ff == '0) begin
                        state_in = S_DONE;
                        res_in   = make_rsp(ST_NOT_FOUND, '0, count_ff);
                     end else begin
                        state_in   = S_SCAN;
                        mem_re     = 1'b1;
                        mem_ra     = head_ff;
                        rd_idx_in  = CW'(1);
                        cmp_idx_in = '0;
                     end
                  end
                  OP_NONE: begin
                     state_in = S_DONE;
                     res_in   = make_rsp(ST_NOT_FOUND, '0, count_ff);
                  end
                  default: begin
                     state_in = S_DONE;
                     res_in   = make_rsp(ST_NOT_FOUND, '0, count_ff);
                  end
               endcase
            end
         end
         S_EXP: begin
            state_in = S_DONE;
            if (mem_rd_ff.due < day_ff) begin
               head_in  = (head_ff == AW'(DEPTH - 1)) ? '0 : head_ff + 1'b1;
               count_in = count_ff - 1'b1;
               res_in   = make_rsp(ST_DONE, mem_rd_ff.key, count_ff - 1'b1);
            end else begin
               res_in = make_rsp(ST_NOT_EXPIRED, '0, count_ff);
            end
         end
         S_SCAN: begin
            if (rd_idx_ff < count_ff) begin
               mem_re    = 1'b1;
               mem_ra    = ring_addr(head_ff, rd_idx_ff[AW-1:0]);
               rd_idx_in = rd_idx_ff + 1'b1;
            end
            if (found_ff) begin
               mem_we = 1'b1;
               mem_wa = ring_addr(head_ff, cmp_idx_ff - 1'b1);
               mem_wd = mem_rd_ff;
            end else if (mem_rd_ff.key == key_ff) begin
               found_in = 1'b1;
            end
            if (CW'(cmp_idx_ff) == count_ff - 1'b1) begin
               state_in = S_DONE;
               if (hit) begin
                  count_in = count_ff - 1'b1;
                  res_in   = make_rsp(ST_DONE, key_ff, count_ff - 1'b1);
               end else begin
                  res_in = make_rsp(ST_NOT_FOUND, '0, count_ff);
               end
            end else begin
               cmp_idx_in = cmp_idx_ff + 1'b1;
            end
         end
         S_DONE: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (rsp_load) begin
         rsp_data_in  = res_ff;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff      <= key_in;
      day_ff      <= day_in;
      rd_idx_ff   <= rd_idx_in;
      cmp_idx_ff  <= cmp_idx_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   `FWEKR_ASSERT(a_count_bound, clock, reset, count_ff <= CW'(DEPTH))

   `FWEKR_ASSERT_NEXT(a_accept_leaves_idle, clock, reset,
      req_valid && req_ready, state_ff != S_IDLE)

   `FWEKR_ASSERT_NEXT(a_push_grows, clock, reset,
      req_valid && req_ready && req_data.operation == OP_PUSH && count_ff != CW'(DEPTH),
      count_ff == CW'($past(count_ff) + 1'b1))

   `FWEKR_ASSERT(a_scan_bound, clock, reset,
      state_ff != S_SCAN || (rd_idx_ff <= count_ff && CW'(cmp_idx_ff) < count_ff))

endmodule

`default_nettype wire

// File: bench/tb.sv
`default_nettype none

module tb;
   import fwekr_pkg::*;

   localparam int QUEUE_DEPTH = DEPTH_DEFAULT;
   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE_CYCLES = 40;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   fifo_with_expiry_and_keyed_remove_unit DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data)
   );

   always #5 clock = ~clock;

   logic [KeyW-1:0] held_keys[$];
   logic [DayW-1:0] held_days[$];
   rsp_type         op_outcomes[$];
   logic [KeyW-1:0] key_pool[8];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int mismatch_count = 0;
   int cycle_count = 0;

   function automatic rsp_type apply_queue_op(input req_type r);
      rsp_type res;
      int      hit;
      res.status = ST_NOT_FOUND;
      res.removed_key = '0;
      case (r.operation)
         OP_PUSH: begin
            if (held_keys.size() >= QUEUE_DEPTH) begin
               res.status = ST_FULL;
            end else begin
               held_keys.push_back(r.key);
               held_days.push_back(r.due_day);
               res.status = ST_DONE;
            end
         end
         OP_EXPIRE: begin
            if (held_keys.size() > 0 && held_days[0] < r.current_day) begin
               res.removed_key = held_keys.pop_front();
               void'(held_days.pop_front());
               res.status = ST_DONE;
            end else begin
               res.status = ST_NOT_EXPIRED;
            end
         end
         OP_REMOVE: begin
            hit = -1;
            for (int i = 0; i < held_keys.size(); i++) begin
               if (hit < 0 && held_keys[i] == r.key) hit = i;
            end
            if (hit >= 0) begin
               res.removed_key = held_keys[hit];
               held_keys.delete(hit);
               held_days.delete(hit);
               res.status = ST_DONE;
            end
         end
         default: ;
      endcase
      res.entry_count = CountW'(held_keys.size());
      return res;
   endfunction

   function automatic req_type make_req(input logic [1:0] op, input logic [KeyW-1:0] key,
                                        input logic [DayW-1:0] due, input logic [DayW-1:0] today);
      req_type r;
      r.operation = op;
      r.key = key;
      r.due_day = due;
      r.current_day = today;
      return r;
   endfunction

   function automatic logic [DayW-1:0] pick_day();
      bit [31:0] raw;
      if ($urandom_range(9) == 0) raw = $urandom_range(511);
      else raw = $urandom_range(365);
      return raw[DayW-1:0];
   endfunction

   function automatic req_type random_request(input int push_pct);
      req_type   r;
      bit [31:0] raw;
      int        roll;
      roll = $urandom_range(99);
      if (roll < push_pct) r.operation = OP_PUSH;
      else if (roll < push_pct + (95 - push_pct) / 2) r.operation = OP_EXPIRE;
      else if (roll < 95) r.operation = OP_REMOVE;
      else r.operation = OP_NONE;
      raw = $urandom();
      if ($urandom_range(9) < 7) r.key = key_pool[$urandom_range(7)];
      else r.key = raw[KeyW-1:0];
      r.due_day = pick_day();
      r.current_day = pick_day();
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch at cycle %0d: %s got %0h want %0h", cycle_count, what, got, want);
      mismatch_count++;
   endtask

   task automatic send_req(input req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      op_outcomes.push_back(apply_queue_op(r));
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (op_outcomes.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin : check_rsp
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (op_outcomes.size() == 0) begin
               report_mismatch("unrequested transaction status", 32'(rsp_data.status), '0);
            end else begin
               want = op_outcomes.pop_front();
               if (rsp_data.status !== want.status)
                  report_mismatch("status", 32'(rsp_data.status), 32'(want.status));
               if (rsp_data.removed_key !== want.removed_key)
                  report_mismatch("removed_key", 32'(rsp_data.removed_key),
                                  32'(want.removed_key));
               if (rsp_data.entry_count !== want.entry_count)
                  report_mismatch("entry_count", 32'(rsp_data.entry_count),
                                  32'(want.entry_count));
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL fifo_with_expiry_and_keyed_remove_unit");
         $finish;
      end
   end

   task automatic test_empty_queue();
      send_req(make_req(OP_EXPIRE, '0, '0, '1));
      send_req(make_req(OP_REMOVE, '0, '0, '0));
      send_req(make_req(OP_NONE, '1, '1, '1));
   endtask

   task automatic test_fill_to_full();
      bit [31:0] raw;
      send_req(make_req(OP_PUSH, '0, '0, '0));
      send_req(make_req(OP_PUSH, '1, '1, '0));
      for (int i = 0; i < QUEUE_DEPTH - 2; i++) begin
         raw = $urandom_range(365);
         send_req(make_req(OP_PUSH, key_pool[2 + i % 6], raw[DayW-1:0], '0));
      end
      send_req(make_req(OP_PUSH, '1, '1, '1));
   endtask

   task automatic test_expire_head();
      // A head due on the current day is not yet overdue.
      send_req(make_req(OP_EXPIRE, '0, '0, 9'd0));
      send_req(make_req(OP_EXPIRE, '0, '0, 9'd1));
      send_req(make_req(OP_EXPIRE, '0, '0, '1));
   endtask

   task automatic test_remove_by_key();
      send_req(make_req(OP_REMOVE, '1, '0, '0));
      send_req(make_req(OP_REMOVE, key_pool[4], '0, '0));
      send_req(make_req(OP_REMOVE, 31'h5555_5555, '0, '0));
      send_req(make_req(OP_NONE, key_pool[3], '1, '0));
   endtask

   task automatic test_random_traffic(input int count, input int s_idle, input int r_idle);
      int push_pct;
      send_idle_pct = s_idle;
      recv_idle_pct = r_idle;
      push_pct = 70;
      for (int i = 0; i < count; i++) begin
         if (i % 32 == 31) push_pct = (push_pct == 70) ? 30 : 70;
         send_req(random_request(push_pct));
      end
      wait_drained();
   endtask

   initial begin
      key_pool[0] = '0;
      key_pool[1] = '1;
      for (int i = 2; i < 8; i++) key_pool[i] = KeyW'($urandom());
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_idle_pct = 21;
      recv_idle_pct = 54;
      test_empty_queue();
      test_fill_to_full();
      test_expire_head();
      test_remove_by_key();
      wait_drained();
      test_random_traffic(225, 21, 54);
      test_random_traffic(225, 54, 21);
      test_random_traffic(225, 0, 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("PASS fifo_with_expiry_and_keyed_remove_unit");
      end else begin
         $display("FAIL fifo_with_expiry_and_keyed_remove_unit");
      end
      $finish;
   end

endmodule

`default_nettype wire
